### src/dpts_pkg.sv
// ----------------------------------------------------------------------------
// dpts_pkg: shared types and codes for the dynamic priority task scheduler
// Operation, queue and task state codes, and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dpts_pkg;

    // Item operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_REFRESH = 3'd2;
    localparam logic [2:0] OP_LOCK    = 3'd3;
    localparam logic [2:0] OP_SCHED   = 3'd4;

    // Queue membership codes
    localparam logic [1:0] Q_FREE   = 2'd0;
    localparam logic [1:0] Q_READY  = 2'd1;
    localparam logic [1:0] Q_WAIT   = 2'd2;
    localparam logic [1:0] Q_ZOMBIE = 2'd3;

    // Task state codes
    localparam logic [1:0] ST_READY  = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_ZOMBIE = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RF,
        S_PREV,
        S_PREV_WR,
        S_SCAN,
        S_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rf_step;
        logic prev_rd;
        logic prev_wr;
        logic scan_step;
        logic k_clr;
        logic finish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic run_sched;
        logic pending;
        logic prev_valid;
        logic k_end;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

### src/dpts_ram.sv
// ----------------------------------------------------------------------------
// dpts_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/dpts_ctrl.sv
// ----------------------------------------------------------------------------
// dpts_ctrl: scheduler sequencer
// Steps an item through execute, refresh sweep, previous-task reset and scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dpts_ctrl
    import dpts_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (st.run_sched) begin
                    cmd.k_clr  = 1'b1;
                    state_next = st.pending ? S_RF : S_PREV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RF: begin
                cmd.rf_step = 1'b1;
                if (st.k_end) begin
                    cmd.k_clr  = 1'b1;
                    state_next = S_PREV;
                end
            end
            S_PREV: begin
                cmd.k_clr = 1'b1;
                if (st.prev_valid) begin
                    cmd.prev_rd = 1'b1;
                    state_next  = S_PREV_WR;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_PREV_WR: begin
                cmd.prev_wr = 1'b1;
                cmd.k_clr   = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.k_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!st.out_full) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/dpts_dp.sv
// ----------------------------------------------------------------------------
// dpts_dp: scheduler datapath
// Task table, priority and counter RAMs, sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpts_dp
    import dpts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    output status_t          st,
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_base,
    input  wire logic [17:0] item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [8:0]       out_data
);

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int KW = $clog2(TASK_SLOTS + 1);
    localparam int SW = (IW > 4) ? IW : 4;

    // Control state
    logic [1:0]    memb_reg  [TASK_SLOTS];
    logic [1:0]    tstate_reg[TASK_SLOTS];
    logic [KW-1:0] cur_reg;
    logic [KW-1:0] k_reg;
    logic          pending_reg, locked_reg, found_reg, out_valid_reg;
    logic [6:0]    base_reg;

    // Payload state
    logic [2:0]    op_reg;
    logic [3:0]    slot_reg;
    logic [1:0]    nst_reg;
    logic [7:0]    prio_reg;
    logic          lockv_reg;
    logic [IW-1:0] pick_reg;
    logic [9:0]    best_reg;
    logic          sw_reg, wake_reg, skip_reg, warn_reg;
    logic [8:0]    out_data_reg;

    // RAM ports
    logic          cnt_we;
    logic [IW-1:0] cnt_waddr;
    logic [9:0]    cnt_wdata, cnt_rdata;
    logic [IW-1:0] prio_raddr;
    logic [7:0]    prio_rdata;

    logic [SW-1:0] slot_w;
    logic [IW-1:0] slot_idx, j_idx, maddr, prev_idx;
    logic [KW-1:0] k_m1;
    logic          slot_ok, proc, is_ready, better, add_ok;
    logic [1:0]    m_cur, s_cur;
    logic [9:0]    floor2, reload;
    logic          found_next;
    logic [IW-1:0] pick_next;
    logic [9:0]    best_next;
    logic [KW-1:0] cur_next;
    logic [KW+4:0] cur_w;

    // Address decode and table read
    always_comb begin
        slot_w   = SW'(slot_reg);
        slot_idx = slot_w[IW-1:0];
        slot_ok  = (32'(slot_reg) < TASK_SLOTS);
        k_m1     = k_reg - 1'b1;
        j_idx    = k_m1[IW-1:0];
        prev_idx = cur_reg[IW-1:0];
        maddr    = cmd.exec ? slot_idx : j_idx;
        m_cur    = memb_reg[maddr];
        s_cur    = tstate_reg[maddr];
        proc     = (k_reg != '0);
        add_ok   = slot_ok && (m_cur == Q_FREE || m_cur == Q_ZOMBIE);
        floor2   = {2'b00, base_reg, 1'b0};
        reload   = floor2 + {2'b00, prio_rdata};
    end

    // Scan compare
    always_comb begin
        is_ready   = (m_cur == Q_READY);
        better     = !found_reg || (cnt_rdata < best_reg);
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (proc && is_ready && better) begin
            found_next = 1'b1;
            pick_next  = j_idx;
            best_next  = cnt_rdata;
        end
        cur_next = found_next ? KW'(pick_next) : KW'(TASK_SLOTS);
    end

    // Counter RAM write select
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = j_idx;
        cnt_wdata = cnt_rdata - 1'b1;
        if (cmd.exec && op_reg == OP_ADD && add_ok) begin
            cnt_we    = 1'b1;
            cnt_waddr = slot_idx;
            cnt_wdata = {2'b00, prio_reg};
        end else if (cmd.rf_step && proc && m_cur == Q_WAIT && s_cur == ST_READY) begin
            cnt_we    = 1'b1;
            cnt_wdata = reload;
        end else if (cmd.prev_wr) begin
            cnt_we    = 1'b1;
            cnt_waddr = prev_idx;
            cnt_wdata = {2'b00, prio_rdata};
        end else if (cmd.scan_step && proc && is_ready && cnt_rdata > floor2) begin
            cnt_we = 1'b1;
        end
        prio_raddr = cmd.prev_rd ? prev_idx : k_reg[IW-1:0];
    end

    dpts_ram #(.WIDTH(8), .DEPTH(TASK_SLOTS)) u_prio_ram (
        .aclk  (aclk),
        .we    (cmd.exec && op_reg == OP_ADD && add_ok),
        .waddr (slot_idx),
        .wdata (prio_reg),
        .raddr (prio_raddr),
        .rdata (prio_rdata)
    );

    dpts_ram #(.WIDTH(10), .DEPTH(TASK_SLOTS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (k_reg[IW-1:0]),
        .rdata (cnt_rdata)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                memb_reg[i]   <= Q_FREE;
                tstate_reg[i] <= ST_READY;
            end
            cur_reg       <= KW'(TASK_SLOTS);
            k_reg         <= '0;
            pending_reg   <= 1'b0;
            locked_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end else begin
            if (cfg_we) begin
                base_reg <= cfg_base;
            end
            if (cmd.k_clr) begin
                k_reg     <= '0;
                found_reg <= 1'b0;
            end else if (cmd.rf_step || cmd.scan_step) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.scan_step) begin
                found_reg <= found_next;
            end
            // Non-schedule operations
            if (cmd.exec) begin
                case (op_reg)
                    OP_ADD: begin
                        if (add_ok) begin
                            memb_reg[slot_idx]   <= Q_READY;
                            tstate_reg[slot_idx] <= ST_READY;
                        end
                    end
                    OP_SET: begin
                        if (slot_ok && m_cur != Q_FREE && nst_reg != ST_BAD) begin
                            tstate_reg[slot_idx] <= nst_reg;
                        end
                    end
                    OP_REFRESH: pending_reg <= 1'b1;
                    OP_LOCK:    locked_reg  <= lockv_reg;
                    default: ;
                endcase
            end
            // Queue refresh sweep
            if (cmd.rf_step && proc) begin
                if (m_cur == Q_READY && s_cur == ST_WAIT) begin
                    memb_reg[j_idx] <= Q_WAIT;
                end else if ((m_cur == Q_READY || m_cur == Q_WAIT) && s_cur == ST_ZOMBIE) begin
                    memb_reg[j_idx] <= Q_ZOMBIE;
                end else if (m_cur == Q_WAIT && s_cur == ST_READY) begin
                    memb_reg[j_idx] <= Q_READY;
                end
            end
            if (cmd.rf_step && st.k_end) begin
                pending_reg <= 1'b0;
            end
            if (cmd.scan_step && st.k_end) begin
                cur_reg <= cur_next;
            end
            // Result handshake
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= item[2:0];
            slot_reg  <= item[6:3];
            nst_reg   <= item[8:7];
            prio_reg  <= item[16:9];
            lockv_reg <= item[17];
            sw_reg    <= 1'b0;
            wake_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            warn_reg  <= 1'b0;
        end
        if (cmd.exec && op_reg == OP_LOCK && lockv_reg) begin
            warn_reg <= locked_reg;
        end
        if (cmd.exec && op_reg == OP_SCHED) begin
            skip_reg <= 1'b1;
        end
        if (cmd.rf_step && proc && (m_cur == Q_READY || m_cur == Q_WAIT)
                && s_cur == ST_ZOMBIE) begin
            wake_reg <= 1'b1;
        end
        if (cmd.scan_step) begin
            pick_reg <= pick_next;
            best_reg <= best_next;
            if (st.k_end) begin
                sw_reg <= (cur_next != cur_reg);
            end
        end
        if (cmd.finish) begin
            out_data_reg <= {warn_reg, skip_reg, wake_reg, sw_reg, cur_w[4:0]};
        end
    end

    assign cur_w = (KW + 5)'(cur_reg);

    // Status
    always_comb begin
        st.run_sched  = (op_reg == OP_SCHED) && !locked_reg;
        st.pending    = pending_reg;
        st.prev_valid = (32'(cur_reg) < TASK_SLOTS);
        st.k_end      = (32'(k_reg) == TASK_SLOTS);
        st.out_full   = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### src/dynamic_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// dynamic_priority_task_scheduler: aging task scheduler, top level
// Non-schedule items pass through execute and done into the result register.
// A schedule item adds a scan sweep over all slots, a counter reset step if a
// task was running, and a refresh sweep if one is pending (sweeps over the RAMs).
// A new item is accepted while the previous result still waits.
// Reset (aresetn low, synchronous) empties all queues, idles, clears locks.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_priority_task_scheduler
    import dpts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config: high_priority_base
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // s_tdata: op[2:0], slot[6:3], new_state[8:7], priority_req[16:9],
    //          lock_value[17], zero pad
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,
    // m_tdata: chosen_task[4:0], switched[5], reaper_wake[6],
    //          skipped_locked[7], deadlock_warn[8], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata
);

    cmd_t       cmd;
    status_t    st;
    logic [8:0] out_data;

    assign cfg_ready = 1'b1;

    dpts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dpts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .cfg_we    (cfg_valid),
        .cfg_base  (cfg_data),
        .item      (s_tdata[17:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {7'd0, out_data};

endmodule

`default_nettype wire

### test/dynamic_priority_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// dynamic_priority_task_scheduler_test: self-checking bench for the scheduler
// Drives directed and random task-table items through the input stream,
// predicts every result with a behavioral scheduler model and checks the
// result stream field by field, across base levels and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_priority_task_scheduler_test;
    import dpts_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [4:0] NO_TASK = 5'd16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic       lock_value;
        logic [7:0] priority_req;
        logic [1:0] new_state;
        logic [3:0] slot;
        logic [2:0] op;
    } task_item_t;

    typedef struct packed {
        logic       deadlock_warn;
        logic       skipped_locked;
        logic       reaper_wake;
        logic       switched;
        logic [4:0] chosen_task;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    dynamic_priority_task_scheduler #(.TASK_SLOTS(SLOTS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // scheduler state mirror
    logic [6:0] base_level;
    logic [1:0] queue_of  [SLOTS];
    logic [1:0] state_of  [SLOTS];
    logic [7:0] prio_of   [SLOTS];
    logic [9:0] count_of  [SLOTS];
    logic [4:0] running;
    logic       refresh_due;
    logic       locked;

    task_item_t    pending_items[$];
    sched_result_t expected_results[$];
    int  idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
    int  errors;
    int  cycles;

    function automatic logic sweep_queues();
        logic wake;
        wake = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (queue_of[i] == Q_READY) begin
                if (state_of[i] == ST_WAIT) begin
                    queue_of[i] = Q_WAIT;
                end else if (state_of[i] == ST_ZOMBIE) begin
                    queue_of[i] = Q_ZOMBIE;
                    wake = 1'b1;
                end
            end else if (queue_of[i] == Q_WAIT) begin
                if (state_of[i] == ST_READY) begin
                    queue_of[i] = Q_READY;
                    count_of[i] = {2'b0, base_level, 1'b0} + {2'b0, prio_of[i]};
                end else if (state_of[i] == ST_ZOMBIE) begin
                    queue_of[i] = Q_ZOMBIE;
                    wake = 1'b1;
                end
            end
        end
        refresh_due = 1'b0;
        return wake;
    endfunction

    // apply one accepted item to the mirror and queue its result
    function automatic void predict_schedule(task_item_t it);
        sched_result_t r;
        logic [4:0] prev, pick;
        logic [9:0] best, floor2;
        logic found;
        r = '0;
        case (it.op)
            OP_ADD: begin
                if (queue_of[it.slot] == Q_FREE || queue_of[it.slot] == Q_ZOMBIE) begin
                    queue_of[it.slot] = Q_READY;
                    state_of[it.slot] = ST_READY;
                    prio_of[it.slot]  = it.priority_req;
                    count_of[it.slot] = {2'b0, it.priority_req};
                end
            end
            OP_SET: begin
                if (queue_of[it.slot] != Q_FREE && it.new_state != ST_BAD)
                    state_of[it.slot] = it.new_state;
            end
            OP_REFRESH: refresh_due = 1'b1;
            OP_LOCK: begin
                if (it.lock_value) begin
                    r.deadlock_warn = locked;
                    locked = 1'b1;
                end else begin
                    locked = 1'b0;
                end
            end
            OP_SCHED: begin
                if (locked) begin
                    r.skipped_locked = 1'b1;
                end else begin
                    prev = running;
                    pick = NO_TASK;
                    best = '0;
                    found = 1'b0;
                    floor2 = {2'b0, base_level, 1'b0};
                    if (refresh_due)
                        r.reaper_wake = sweep_queues();
                    if (prev != NO_TASK)
                        count_of[prev[3:0]] = {2'b0, prio_of[prev[3:0]]};
                    for (int i = 0; i < SLOTS; i++) begin
                        if (queue_of[i] == Q_READY) begin
                            if (!found || count_of[i] < best) begin
                                found = 1'b1;
                                pick = 5'(i);
                                best = count_of[i];
                            end
                            if (count_of[i] > floor2)
                                count_of[i] = count_of[i] - 10'd1;
                        end
                    end
                    running = pick;
                    r.switched = (pick != prev);
                end
            end
            default: ;
        endcase
        r.chosen_task = running;
        expected_results.push_back(r);
    endfunction

    function automatic logic stall_now(logic on);
        int pct;
        pct = (idle_mode == 3) ? 9 : 71;
        return on && ($urandom_range(99) < pct);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_schedule(pending_items.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 &&
                    !stall_now(idle_mode == 1 || idle_mode == 3)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'b0, pending_items[0]};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        sched_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[8:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.chosen_task != want.chosen_task) begin
                        $display("%0t: chosen_task expected %0d actual %0d",
                                 $time, want.chosen_task, got.chosen_task);
                        errors++;
                    end
                    if (got.switched != want.switched) begin
                        $display("%0t: switched expected %b actual %b",
                                 $time, want.switched, got.switched);
                        errors++;
                    end
                    if (got.reaper_wake != want.reaper_wake) begin
                        $display("%0t: reaper_wake expected %b actual %b",
                                 $time, want.reaper_wake, got.reaper_wake);
                        errors++;
                    end
                    if (got.skipped_locked != want.skipped_locked) begin
                        $display("%0t: skipped_locked expected %b actual %b",
                                 $time, want.skipped_locked, got.skipped_locked);
                        errors++;
                    end
                    if (got.deadlock_warn != want.deadlock_warn) begin
                        $display("%0t: deadlock_warn expected %b actual %b",
                                 $time, want.deadlock_warn, got.deadlock_warn);
                        errors++;
                    end
                end
            end
            m_tready <= !stall_now(idle_mode == 2 || idle_mode == 3);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[dynamic_priority_task_scheduler] ERROR");
            $finish;
        end
    end

    function automatic task_item_t make_item(logic [2:0] op, logic [3:0] slot,
                                             logic [1:0] nst, logic [7:0] prio,
                                             logic lockv);
        task_item_t it;
        it.op = op;
        it.slot = slot;
        it.new_state = nst;
        it.priority_req = prio;
        it.lock_value = lockv;
        return it;
    endfunction

    // mostly well-formed traffic with random content
    function automatic task_item_t random_item();
        task_item_t it;
        int r;
        it = 18'($urandom);
        r = $urandom_range(99);
        if (r < 18)       it.op = OP_ADD;
        else if (r < 40)  it.op = OP_SET;
        else if (r < 52)  it.op = OP_REFRESH;
        else if (r < 56)  begin it.op = OP_LOCK; it.lock_value = 1'b1; end
        else if (r < 64)  begin it.op = OP_LOCK; it.lock_value = 1'b0; end
        else if (r < 97)  it.op = OP_SCHED;
        else              it.op = OP_SCHED + 3'($urandom_range(3, 1));
        if (it.op == OP_SET && $urandom_range(9) != 0)
            it.new_state = 2'($urandom_range(2));
        return it;
    endfunction

    // wait for the block to go quiet
    task automatic drain();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_base(logic [6:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_level = value;
    endtask

    // stimulus
    initial begin
        logic [6:0] bases[8];
        errors = 0;
        cycles = 0;
        idle_mode = 0;
        base_level = '0;
        running = NO_TASK;
        refresh_due = 1'b0;
        locked = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            queue_of[i] = Q_FREE;
            state_of[i] = ST_READY;
            prio_of[i] = '0;
            count_of[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        write_base(7'd3);
        // directed: extremes and special cases
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 4'd15, ST_READY, 8'd255, 1'b1));
        pending_items.push_back(make_item(OP_ADD, 4'd0, ST_READY, 8'd77, 1'b0));
        pending_items.push_back(make_item(OP_SET, 4'd5, ST_WAIT, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SET, 4'd0, ST_BAD, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SET, 4'd15, ST_WAIT, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_REFRESH, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_LOCK, 4'd0, ST_READY, 8'd0, 1'b1));
        pending_items.push_back(make_item(OP_LOCK, 4'd0, ST_READY, 8'd0, 1'b1));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_LOCK, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SET, 4'd15, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_REFRESH, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SET, 4'd0, ST_ZOMBIE, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_REFRESH, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        pending_items.push_back(make_item(OP_ADD, 4'd0, ST_READY, 8'd128, 1'b0));
        pending_items.push_back(make_item(OP_SCHED + 3'd1, 4'd9, ST_BAD, 8'hff, 1'b1));
        pending_items.push_back(make_item(OP_SCHED + 3'd2, 4'd3, ST_WAIT, 8'd1, 1'b0));
        pending_items.push_back(make_item(OP_SCHED + 3'd3, 4'd6, ST_ZOMBIE, 8'd2, 1'b1));
        pending_items.push_back(make_item(OP_SCHED, 4'd0, ST_READY, 8'd0, 1'b0));
        drain();

        // random phases over base levels and idling patterns
        bases = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd0, 7'd127, 7'd10, 7'd100};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 6) write_base(bases[ph]);
            else        write_base(7'($urandom_range(127)));
            idle_mode = ph % 4;
            for (int n = 0; n < 228; n++)
                pending_items.push_back(random_item());
            drain();
        end

        if (errors == 0) begin
            $display("[dynamic_priority_task_scheduler] OK");
        end else begin
            $display("[dynamic_priority_task_scheduler] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
